>>> sv/egbr_pkg.sv
package egbr_pkg;

	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 6;
	localparam int VAL_W   = 32;
	localparam int ST_W    = 3;
	localparam int POS_W   = 13;

	typedef logic [OP_W-1:0] opcode_t;
	typedef logic [ST_W-1:0] status_t;

	localparam opcode_t OP_LOAD  = 3'd0;
	localparam opcode_t OP_BITS  = 3'd1;
	localparam opcode_t OP_UE    = 3'd2;
	localparam opcode_t OP_SE    = 3'd3;
	localparam opcode_t OP_CLEAR = 3'd4;

	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_COUNT  = 3'd1;
	localparam status_t ST_NODATA = 3'd2;
	localparam status_t ST_PREFIX = 3'd3;
	localparam status_t ST_FULL   = 3'd4;

	// longest field and longest prefix
	localparam logic [COUNT_W-1:0] MAX_FIELD  = 6'd32;
	localparam logic [COUNT_W-1:0] MAX_ZEROS  = 6'd31;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_BIT   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

endpackage

>>> sv/egbr_req_if.sv
interface egbr_req_if;
	import egbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [BYTE_W-1:0]   data_byte;
	logic [COUNT_W-1:0]  bit_count;

	modport source (output valid, opcode, data_byte, bit_count, input ready);
	modport sink   (input valid, opcode, data_byte, bit_count, output ready);

endinterface

>>> sv/egbr_rsp_if.sv
interface egbr_rsp_if;
	import egbr_pkg::*;

	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  value;
	logic [ST_W-1:0]   status;
	logic [POS_W-1:0]  bit_position;
	logic [POS_W-1:0]  bits_left;

	modport source (output valid, value, status, bit_position, bits_left, input ready);
	modport sink   (input valid, value, status, bit_position, bits_left, output ready);

endinterface

>>> sv/exp_golomb_bit_reader.sv
// Exp-Golomb bit reader. Load items append bytes to an internal byte buffer;
// read items take bits from it MSB first, one bit per cycle apart from a
// fetch step for each buffer byte it touches, through a single bit extractor
// fed by the buffer's one registered read port. Every item gives one result.
// Load, clear, unused opcodes and reads that fail their up-front checks go
// from idle straight to the done state. A ue/se code with z leading zeros
// consumes 2z+1 bits. The block takes one item at a time and accepts the
// next once the previous result sits in the output register.
module exp_golomb_bit_reader #(
	parameter int BUFFER_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	egbr_req_if.sink    req,
	egbr_rsp_if.source  rsp
);
	import egbr_pkg::*;

	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int LW = $clog2(BUFFER_BYTES + 1);
	localparam int PW = $clog2(BUFFER_BYTES * 8 + 1);
	localparam int CW = (PW > COUNT_W) ? PW : COUNT_W;

	logic [BYTE_W-1:0]  mem [BUFFER_BYTES];
	logic [BYTE_W-1:0]  rdata_q;

	state_t             state_q;
	logic [LW-1:0]      loaded_q;
	logic [PW-1:0]      pos_q;
	opcode_t            op_q;
	status_t            st_q;
	logic               prefix_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] zeros_q;
	logic [VAL_W-1:0]   acc_q;

	logic               rsp_valid_q;
	logic [VAL_W-1:0]   rsp_value_q;
	status_t            rsp_status_q;
	logic [POS_W-1:0]   rsp_pos_q;
	logic [POS_W-1:0]   rsp_left_q;

	logic [PW-1:0]      total;
	logic [PW-1:0]      rem;
	logic               accept;
	logic               full;
	logic               mem_we;
	logic               cur_bit;
	logic               byte_end;
	logic               out_free;
	logic [VAL_W-1:0]   mag;
	logic [VAL_W-1:0]   result;

	assign total    = PW'({loaded_q, 3'b000});
	assign rem      = total - pos_q;
	assign accept   = req.valid && req.ready;
	assign full     = (loaded_q == LW'(BUFFER_BYTES));
	assign mem_we   = accept && (req.opcode == OP_LOAD) && !full;
	assign cur_bit  = rdata_q[~pos_q[2:0]];
	assign byte_end = (pos_q[2:0] == 3'd7);
	assign out_free = !rsp_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);

	// acc holds k+1 for ue/se: the terminating one followed by the suffix
	assign mag = {1'b0, acc_q[VAL_W-1:1]};
	always_comb begin
		result = '0;
		if (st_q == ST_OK) begin
			case (op_q)
				OP_BITS: result = acc_q;
				OP_UE:   result = acc_q - VAL_W'(1);
				OP_SE:   result = acc_q[0] ? (VAL_W'(0) - mag) : mag;
				default: result = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[loaded_q[AW-1:0]] <= req.data_byte;
		end
		rdata_q <= mem[pos_q[AW+2:3]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in S_DONE the output register is reloaded below
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= req.opcode;
						st_q     <= ST_OK;
						acc_q    <= '0;
						zeros_q  <= '0;
						cnt_q    <= req.bit_count;
						prefix_q <= 1'b0;
						state_q  <= S_DONE;
						case (req.opcode)
							OP_LOAD: begin
								if (full) begin
									st_q <= ST_FULL;
								end else begin
									loaded_q <= loaded_q + LW'(1);
								end
							end
							OP_BITS: begin
								if (req.bit_count > MAX_FIELD) begin
									st_q <= ST_COUNT;
								end else if (CW'(req.bit_count) > CW'(rem)) begin
									st_q <= ST_NODATA;
								end else if (req.bit_count != '0) begin
									state_q <= S_FETCH;
								end
							end
							OP_UE, OP_SE: begin
								prefix_q <= 1'b1;
								state_q  <= S_FETCH;
							end
							OP_CLEAR: begin
								loaded_q <= '0;
								pos_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				S_FETCH: begin
					state_q <= S_BIT;
				end
				S_BIT: begin
					if (prefix_q && rem == '0) begin
						st_q    <= ST_NODATA;
						state_q <= S_DONE;
					end else begin
						pos_q   <= pos_q + PW'(1);
						acc_q   <= {acc_q[VAL_W-2:0], cur_bit};
						state_q <= byte_end ? S_FETCH : S_BIT;
						if (prefix_q) begin
							if (cur_bit) begin
								if (zeros_q == '0) begin
									state_q <= S_DONE;
								end else if (CW'(zeros_q) >= CW'(rem)) begin
									// suffix would run past the data; the one stays consumed
									st_q    <= ST_NODATA;
									state_q <= S_DONE;
								end else begin
									prefix_q <= 1'b0;
									cnt_q    <= zeros_q;
								end
							end else begin
								zeros_q <= zeros_q + COUNT_W'(1);
								if (zeros_q == MAX_ZEROS) begin
									st_q    <= ST_PREFIX;
									state_q <= S_DONE;
								end
							end
						end else begin
							cnt_q <= cnt_q - COUNT_W'(1);
							if (cnt_q == COUNT_W'(1)) begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_value_q  <= result;
						rsp_status_q <= st_q;
						rsp_pos_q    <= POS_W'(pos_q);
						rsp_left_q   <= POS_W'(rem);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.value        = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.bit_position = rsp_pos_q;
	assign rsp.bits_left    = rsp_left_q;

	a_pos_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= total)
		else $error("read position beyond loaded data");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= LW'(BUFFER_BYTES))
		else $error("byte count above buffer size");

	a_fetch_then_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |=> state_q == S_BIT)
		else $error("fetch not followed by bit step");

	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BIT && !prefix_q) |-> (cnt_q != '0 && cnt_q <= MAX_FIELD))
		else $error("field bit count out of range");

	a_field_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BIT && !prefix_q) |-> CW'(cnt_q) <= CW'(rem))
		else $error("field read runs past loaded data");

endmodule
